// ===== hdl/qts_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qts_pkg: shared types and constants for the quote-aware token splitter
// Byte codes, result kinds, quote modes and register indexes.
// ----------------------------------------------------------------------------
package qts_pkg;

    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_COLON  = 8'h3A;

    // number of delimiter registers in the register map
    localparam int DELIM_REGS = 4;

    // register indexes
    localparam logic [2:0] REG_DELIM_COUNT = 3'd0;
    localparam logic [2:0] REG_DELIM_A     = 3'd1;

    // max results caused by one request
    localparam int MAX_RESULTS = 4;

    typedef enum logic [1:0] {
        KIND_DATA       = 2'd0,
        KIND_TOKEN_END  = 2'd1,
        KIND_STRING_END = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        QM_NONE   = 2'd0,
        QM_DOUBLE = 2'd1,
        QM_SINGLE = 2'd2
    } qmode_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] ch;
        logic       unmatched;
        logic       last;
    } res_t;

    function automatic res_t make_res(kind_t kind, logic [7:0] ch, logic unmatched);
        res_t r;
        r.kind      = kind;
        r.ch        = ch;
        r.unmatched = unmatched;
        r.last      = 1'b0;
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/quote_aware_token_splitter.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// quote_aware_token_splitter: byte-stream tokenizer with quote handling
// Splits strings into tokens at up to MAX_DELIMS delimiter bytes, strips
// single/double quotes, handles backslash-escaped quotes.
// ----------------------------------------------------------------------------
//
// channel  dir  handshake          payload
// -------  ---  -----------------  ------------------------------------------
// s_*      in   s_tvalid/s_tready  tdata: in_char, tuser: char_present,
//                                  tlast: string_end
// m_*      out  m_tvalid/m_tready  tdata: out_char, unmatched_quote,
//                                  tuser: out_kind, tlast: run_last
// cfg_*    in   cfg_we             cfg_index, cfg_data (no read-back)
//
// One request is decoded in the cycle it is accepted; its zero to four
// results land in a four-entry result buffer and drain one per cycle
// while m_tready is high. Requests giving one result each stream at one
// per cycle while m_tready is high: the buffer takes a new request in the
// cycle its last entry is taken. Output stalls hold the buffer and stall
// the input once the buffer holds more than the entry being taken. rst_n
// clears state and buffer and resets the registers to one colon delimiter.
// ----------------------------------------------------------------------------
module quote_aware_token_splitter #(
    parameter int MAX_DELIMS = 4
) (
    input  wire        clk,
    input  wire        rst_n,

    input  wire        cfg_we,
    input  wire  [2:0] cfg_index,
    input  wire  [7:0] cfg_data,

    input  wire        s_tvalid,
    output logic       s_tready,
    input  wire  [7:0] s_tdata,   // [7:0] in_char
    input  wire        s_tuser,   // [0] char_present
    input  wire        s_tlast,   // string_end

    output logic       m_tvalid,
    input  wire        m_tready,
    output logic [15:0] m_tdata,  // [7:0] out_char, [8] unmatched_quote, rest 0
    output logic [1:0] m_tuser,   // [1:0] out_kind
    output logic       m_tlast    // run_last
);

    localparam int RES_W = $clog2(qts_pkg::MAX_RESULTS);

    // configuration
    logic [2:0] delim_count_reg;
    logic [7:0] delim_reg [MAX_DELIMS];

    // parser state
    qts_pkg::qmode_t quote_reg, quote_next;
    logic            hb_reg, hb_next;     // backslash held for look-ahead
    logic            tn_reg, tn_next;     // current token has data

    // result buffer
    qts_pkg::res_t   res_reg [qts_pkg::MAX_RESULTS];
    qts_pkg::res_t   res_v   [qts_pkg::MAX_RESULTS];
    logic [RES_W:0]  cnt_reg, cnt_next;
    logic [RES_W-1:0] rd_reg, rd_next;
    logic [RES_W:0]  res_n;

    logic s_fire, m_fire;
    logic c_is_delim, bs_is_delim;

    assign s_fire = s_tvalid && s_tready;
    assign m_fire = m_tvalid && m_tready;

    // free to take a request when the buffer empties this cycle
    assign s_tready = (cnt_reg == '0) || (cnt_reg == (RES_W + 1)'(1) && m_tready);

    // ---------------------------------------------------------------- config
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delim_count_reg <= 3'd1;
            for (int i = 0; i < MAX_DELIMS; i++)
            begin
                delim_reg[i] <= (i == 0) ? qts_pkg::CH_COLON : 8'h00;
            end
        end
        else if (cfg_we)
        begin
            if (cfg_index == qts_pkg::REG_DELIM_COUNT)
            begin
                delim_count_reg <= cfg_data[2:0];
            end
            for (int i = 0; i < MAX_DELIMS; i++)
            begin
                // slots past the register map are never written
                if (i < qts_pkg::DELIM_REGS && cfg_index == qts_pkg::REG_DELIM_A + 3'(i))
                begin
                    delim_reg[i] <= cfg_data;
                end
            end
        end
    end

    // delimiter match; counts above MAX_DELIMS saturate naturally
    always_comb
    begin
        c_is_delim  = 1'b0;
        bs_is_delim = 1'b0;
        for (int i = 0; i < MAX_DELIMS; i++)
        begin
            if (32'(i) < 32'(delim_count_reg))
            begin
                if (delim_reg[i] == s_tdata)
                begin
                    c_is_delim = 1'b1;
                end
                if (delim_reg[i] == qts_pkg::CH_BSLASH)
                begin
                    bs_is_delim = 1'b1;
                end
            end
        end
    end

    // ---------------------------------------------------------------- decode
    // Works out all results of the offered request plus the next state.
    always_comb
    begin
        logic [7:0] c;
        logic [7:0] oq;
        logic       is_quote;
        logic       plain;
        qts_pkg::qmode_t qm;
        logic       hb;
        logic       tn;

        c        = s_tdata;
        qm       = quote_reg;
        hb       = hb_reg;
        tn       = tn_reg;
        res_n    = '0;
        plain    = s_tuser;
        oq       = (quote_reg == qts_pkg::QM_DOUBLE) ? qts_pkg::CH_DQUOTE : qts_pkg::CH_SQUOTE;
        is_quote = (c == qts_pkg::CH_DQUOTE) || (c == qts_pkg::CH_SQUOTE);
        for (int i = 0; i < qts_pkg::MAX_RESULTS; i++)
        begin
            res_v[i] = '0;
        end

        if (s_tuser)
        begin
            if (hb)
            begin
                hb = 1'b0;
                if ((qm == qts_pkg::QM_NONE) ? is_quote : (c == oq))
                begin
                    // escaped quote: literal data
                    res_v[res_n[RES_W-1:0]] = qts_pkg::make_res(qts_pkg::KIND_DATA, c, 1'b0);
                    res_n = res_n + 1'b1;
                    tn    = 1'b1;
                    plain = 1'b0;
                end
                else if (qm == qts_pkg::QM_NONE && bs_is_delim)
                begin
                    res_v[res_n[RES_W-1:0]] =
                        qts_pkg::make_res(qts_pkg::KIND_TOKEN_END, 8'h00, 1'b0);
                    res_n = res_n + 1'b1;
                    tn    = 1'b0;
                end
                else
                begin
                    res_v[res_n[RES_W-1:0]] =
                        qts_pkg::make_res(qts_pkg::KIND_DATA, qts_pkg::CH_BSLASH, 1'b0);
                    res_n = res_n + 1'b1;
                    tn    = 1'b1;
                end
            end

            if (plain)
            begin
                if (qm == qts_pkg::QM_NONE && is_quote)
                begin
                    qm = (c == qts_pkg::CH_DQUOTE) ? qts_pkg::QM_DOUBLE : qts_pkg::QM_SINGLE;
                end
                else if (c == qts_pkg::CH_BSLASH)
                begin
                    hb = 1'b1;
                end
                else if (qm != qts_pkg::QM_NONE && c == oq)
                begin
                    qm = qts_pkg::QM_NONE;
                end
                else if (qm == qts_pkg::QM_NONE && c_is_delim)
                begin
                    res_v[res_n[RES_W-1:0]] =
                        qts_pkg::make_res(qts_pkg::KIND_TOKEN_END, 8'h00, 1'b0);
                    res_n = res_n + 1'b1;
                    tn    = 1'b0;
                end
                else
                begin
                    res_v[res_n[RES_W-1:0]] = qts_pkg::make_res(qts_pkg::KIND_DATA, c, 1'b0);
                    res_n = res_n + 1'b1;
                    tn    = 1'b1;
                end
            end
        end

        if (s_tlast)
        begin
            // trailing backslash flushes as an ordinary byte, or as a delimiter outside quotes
            if (hb)
            begin
                if (qm == qts_pkg::QM_NONE && bs_is_delim)
                begin
                    res_v[res_n[RES_W-1:0]] =
                        qts_pkg::make_res(qts_pkg::KIND_TOKEN_END, 8'h00, 1'b0);
                    res_n = res_n + 1'b1;
                    tn    = 1'b0;
                end
                else
                begin
                    res_v[res_n[RES_W-1:0]] =
                        qts_pkg::make_res(qts_pkg::KIND_DATA, qts_pkg::CH_BSLASH, 1'b0);
                    res_n = res_n + 1'b1;
                    tn    = 1'b1;
                end
            end
            if (tn)
            begin
                res_v[res_n[RES_W-1:0]] =
                    qts_pkg::make_res(qts_pkg::KIND_TOKEN_END, 8'h00, 1'b0);
                res_n = res_n + 1'b1;
            end
            res_v[res_n[RES_W-1:0]] = qts_pkg::make_res(qts_pkg::KIND_STRING_END, 8'h00,
                                                        qm != qts_pkg::QM_NONE);
            res_n = res_n + 1'b1;
            qm    = qts_pkg::QM_NONE;
            hb    = 1'b0;
            tn    = 1'b0;
        end

        if (res_n != '0)
        begin
            res_v[RES_W'(res_n - 1'b1)].last = 1'b1;
        end

        quote_next = qm;
        hb_next    = hb;
        tn_next    = tn;
    end

    // --------------------------------------------------------- buffer control
    always_comb
    begin
        cnt_next = cnt_reg;
        rd_next  = rd_reg;
        if (s_fire)
        begin
            cnt_next = res_n;
            rd_next  = '0;
        end
        else if (m_fire)
        begin
            cnt_next = cnt_reg - 1'b1;
            rd_next  = rd_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quote_reg <= qts_pkg::QM_NONE;
            hb_reg    <= 1'b0;
            tn_reg    <= 1'b0;
            cnt_reg   <= '0;
            rd_reg    <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            rd_reg  <= rd_next;
            if (s_fire)
            begin
                quote_reg <= quote_next;
                hb_reg    <= hb_next;
                tn_reg    <= tn_next;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            for (int i = 0; i < qts_pkg::MAX_RESULTS; i++)
            begin
                res_reg[i] <= res_v[i];
            end
        end
    end

    // ---------------------------------------------------------------- output
    assign m_tvalid = (cnt_reg != '0);
    assign m_tdata  = {7'd0, res_reg[rd_reg].unmatched, res_reg[rd_reg].ch};
    assign m_tuser  = res_reg[rd_reg].kind;
    assign m_tlast  = res_reg[rd_reg].last;

    // ------------------------------------------------------------ assertions
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= (RES_W + 1)'(qts_pkg::MAX_RESULTS))
        else $error("result buffer count out of range");

    a_strend_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == qts_pkg::KIND_STRING_END |-> m_tlast)
        else $error("end of string is not the last result");

    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        s_fire && s_tlast |=> quote_reg == qts_pkg::QM_NONE && !hb_reg && !tn_reg)
        else $error("state not cleared after end of string");

    a_end_has_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_fire && s_tlast |=> m_tvalid)
        else $error("end of string produced no result");

    a_nondata_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != qts_pkg::KIND_DATA |-> m_tdata[7:0] == 8'h00)
        else $error("non-data result carries a byte");

endmodule
`default_nettype wire

// ===== sim/quote_aware_token_splitter_tb.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// quote_aware_token_splitter_tb: self-checking bench for the token splitter
// Streams short strings through the splitter under several delimiter
// settings. A cycle-free model of the tokenizer predicts every result; the
// monitor checks each result against the oldest prediction, field by field.
// Sender bursts, receiver stalls and one long receiver hold-off exercise the
// result buffer and input back-pressure.
// ----------------------------------------------------------------------------
module quote_aware_token_splitter_tb;

    localparam int NUM_PHASES  = 6;    // random phases, each with its own setting
    localparam int PHASE_REQS  = 48;   // minimum meaningful requests per random phase
    localparam int HOLD_CYCLES = 400;  // long receiver hold-off
    localparam int MAX_REPORTS = 100;  // cap on printed mismatch lines

    // first index past the delimiter slots; writes there must be dropped
    localparam logic [2:0] REG_FIRST_UNMAPPED =
        qts_pkg::REG_DELIM_A + 3'(qts_pkg::DELIM_REGS);

    typedef struct packed {
        logic [7:0] ch;
        logic       present;
        logic       fin;
    } char_req_t;

    // ------------------------------------------------------------------
    // DUT signals; every input is known from time zero
    // ------------------------------------------------------------------
    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [7:0]  cfg_data  = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;   // [7:0] in_char
    logic        s_tuser   = 1'b0; // [0] char_present
    logic        s_tlast   = 1'b0; // string_end
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;          // [7:0] out_char, [8] unmatched_quote
    logic [1:0]  m_tuser;          // [1:0] out_kind
    logic        m_tlast;          // run_last

    quote_aware_token_splitter #(.MAX_DELIMS(4)) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always #2 clk = ~clk;

    // ------------------------------------------------------------------
    // Tokenizer model: its own copy of registers and string state
    // ------------------------------------------------------------------
    logic [7:0]      delim_count_m = 3'd1;
    logic [7:0]      delims_m [qts_pkg::DELIM_REGS] =
        '{qts_pkg::CH_COLON, 8'h00, 8'h00, 8'h00};
    qts_pkg::qmode_t quote_m       = qts_pkg::QM_NONE;
    logic            held_bs_m     = 1'b0;
    logic            tok_open_m    = 1'b0;

    qts_pkg::res_t step_results [$];     // results of the request being modeled
    qts_pkg::res_t expected_results [$]; // predicted, not yet seen on m_*
    char_req_t     pending_req [$];      // requests not yet offered

    // bookkeeping
    int   requests_queued = 0;
    int   requests_taken  = 0;
    int   results_checked = 0;
    int   strings_closed  = 0;
    int   open_quote_ends = 0;
    int   cfg_writes      = 0;
    int   settings_used   = 1;
    int   err_count       = 0;

    function automatic logic is_delim_byte(logic [7:0] c);
        int n;
        n = (delim_count_m > qts_pkg::DELIM_REGS) ? qts_pkg::DELIM_REGS
                                                  : int'(delim_count_m);
        for (int i = 0; i < n; i++)
            if (delims_m[i] == c)
                return 1'b1;
        return 1'b0;
    endfunction

    function automatic logic [7:0] open_quote_byte();
        return (quote_m == qts_pkg::QM_DOUBLE) ? qts_pkg::CH_DQUOTE : qts_pkg::CH_SQUOTE;
    endfunction

    task automatic emit_res(qts_pkg::kind_t k, logic [7:0] c, logic um);
        qts_pkg::res_t r;
        r.kind      = k;
        r.ch        = c;
        r.unmatched = um;
        r.last      = 1'b0;
        step_results.insert(step_results.size(), r);
    endtask

    task automatic data_out(logic [7:0] c);
        emit_res(qts_pkg::KIND_DATA, c, 1'b0);
        tok_open_m = 1'b1;
    endtask

    task automatic token_out();
        emit_res(qts_pkg::KIND_TOKEN_END, 8'h00, 1'b0);
        tok_open_m = 1'b0;
    endtask

    // a held backslash that escapes nothing: data, or a delimiter outside quotes
    task automatic backslash_flush();
        held_bs_m = 1'b0;
        if (quote_m == qts_pkg::QM_NONE && is_delim_byte(qts_pkg::CH_BSLASH))
            token_out();
        else
            data_out(qts_pkg::CH_BSLASH);
    endtask

    task automatic plain_char(logic [7:0] c);
        if (quote_m == qts_pkg::QM_NONE
            && (c == qts_pkg::CH_DQUOTE || c == qts_pkg::CH_SQUOTE))
            quote_m = (c == qts_pkg::CH_DQUOTE) ? qts_pkg::QM_DOUBLE : qts_pkg::QM_SINGLE;
        else if (c == qts_pkg::CH_BSLASH)
            held_bs_m = 1'b1;
        else if (quote_m != qts_pkg::QM_NONE && c == open_quote_byte())
            quote_m = qts_pkg::QM_NONE;
        else if (quote_m == qts_pkg::QM_NONE && is_delim_byte(c))
            token_out();
        else
            data_out(c);
    endtask

    // model one accepted request and queue its results
    task automatic predict_request(logic [7:0] c, logic present, logic fin);
        logic esc;
        step_results.delete();
        if (present)
        begin
            if (held_bs_m)
            begin
                esc = (quote_m == qts_pkg::QM_NONE)
                    ? (c == qts_pkg::CH_DQUOTE || c == qts_pkg::CH_SQUOTE)
                    : (c == open_quote_byte());
                if (esc)
                begin
                    held_bs_m = 1'b0;
                    data_out(c);
                end
                else
                begin
                    backslash_flush();
                    plain_char(c);
                end
            end
            else
            begin
                plain_char(c);
            end
        end
        if (fin)
        begin
            if (held_bs_m)
                backslash_flush();
            if (tok_open_m)
                token_out();
            emit_res(qts_pkg::KIND_STRING_END, 8'h00, quote_m != qts_pkg::QM_NONE);
            quote_m    = qts_pkg::QM_NONE;
            held_bs_m  = 1'b0;
            tok_open_m = 1'b0;
        end
        if (step_results.size() > 0)
            step_results[step_results.size() - 1].last = 1'b1;
        foreach (step_results[i])
            expected_results.insert(expected_results.size(), step_results[i]);
    endtask

    // ------------------------------------------------------------------
    // Monitor: check results first, then model the request taken at this edge
    // ------------------------------------------------------------------
    logic          offer_done = 1'b0;  // current request accepted, driver may move on
    qts_pkg::res_t exp_r;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_results.size() == 0)
                begin
                    err_count++;
                    if (err_count <= MAX_REPORTS)
                        $display("%0t: unexpected result kind=%0d tdata=%h last=%b",
                                 $time, m_tuser, m_tdata, m_tlast);
                end
                else
                begin
                    exp_r = expected_results.pop_front();
                    results_checked++;
                    if (m_tuser !== exp_r.kind
                        || m_tdata !== {7'd0, exp_r.unmatched, exp_r.ch}
                        || m_tlast !== exp_r.last)
                    begin
                        err_count++;
                        // fields: kind / char / unmatched / last
                        if (err_count <= MAX_REPORTS)
                            $display("%0t: mismatch expected %0d/%h/%b/%b got %0d/%h/%b",
                                     $time, exp_r.kind, exp_r.ch, exp_r.unmatched,
                                     exp_r.last, m_tuser, m_tdata, m_tlast);
                    end
                    if (exp_r.kind == qts_pkg::KIND_STRING_END)
                    begin
                        strings_closed++;
                        if (exp_r.unmatched)
                            open_quote_ends++;
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                predict_request(s_tdata, s_tuser, s_tlast);
                requests_taken++;
                offer_done = 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Driver: bursts of random length, random gaps (often none)
    // ------------------------------------------------------------------
    int        burst_left = 4;
    int        gap_left   = 0;
    char_req_t cur_req;

    always @(negedge clk)
    begin
        if (!s_tvalid || offer_done)
        begin
            offer_done = 1'b0;
            if (gap_left > 0)
            begin
                s_tvalid <= 1'b0;
                gap_left--;
            end
            else if (pending_req.size() > 0)
            begin
                cur_req = pending_req.pop_front();
                s_tdata  <= cur_req.ch;
                s_tuser  <= cur_req.present;
                s_tlast  <= cur_req.fin;
                s_tvalid <= 1'b1;
                if (burst_left <= 1)
                begin
                    burst_left = $urandom_range(1, 16);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
                else
                begin
                    burst_left--;
                end
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: stall mode is redrawn at random from four modes; a long hold-off
    // on request lets the result buffer fill and back-pressure the input
    // ------------------------------------------------------------------
    int   rx_tick    = 0;
    int   rx_mode    = 0;
    int   hold_left  = 0;
    logic hold_armed = 1'b0;

    always @(negedge clk)
    begin
        rx_tick++;
        if (hold_armed)
        begin
            hold_armed = 1'b0;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
        begin
            if (rx_tick % 48 == 0)
                rx_mode = $urandom_range(0, 3);
            case (rx_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= 1'($urandom_range(0, 1));
                2:       m_tready <= ($urandom_range(0, 3) == 0);
                default: m_tready <= ((rx_tick % 8) < 5);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_item(logic [7:0] c, logic present, logic fin);
        char_req_t r;
        r.ch      = c;
        r.present = present;
        r.fin     = fin;
        pending_req.insert(pending_req.size(), r);
        requests_queued++;
    endtask

    task automatic push_text(string s, logic close);
        for (int i = 0; i < s.len(); i++)
            push_item(s[i], 1'b1, close && (i == s.len() - 1));
    endtask

    function automatic logic [7:0] pick_delim_byte();
        case ($urandom_range(0, 9))
            0:       return qts_pkg::CH_COLON;
            1:       return ",";
            2:       return " ";
            3:       return ";";
            4:       return qts_pkg::CH_BSLASH;
            5:       return qts_pkg::CH_DQUOTE;
            6:       return qts_pkg::CH_SQUOTE;
            7:       return 8'h00;
            8:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] active_delim();
        int n;
        n = (delim_count_m > qts_pkg::DELIM_REGS) ? qts_pkg::DELIM_REGS
                                                  : int'(delim_count_m);
        if (n == 0)
            return "a" + 8'($urandom_range(0, 25));
        return delims_m[2'($urandom_range(0, n - 1))];
    endfunction

    function automatic logic [7:0] noise_char();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return "a" + 8'($urandom_range(0, 25));
            4:          return 8'($urandom);
            5, 6:       return active_delim();
            7:          return $urandom_range(0, 1) ? qts_pkg::CH_DQUOTE : qts_pkg::CH_SQUOTE;
            8:          return qts_pkg::CH_BSLASH;
            default:    return $urandom_range(0, 1) ? 8'hFF : 8'h00;
        endcase
    endfunction

    // one string: mostly words, delimiters, quoted sections and escapes;
    // the rest is raw noise. Returns the number of meaningful requests.
    task automatic queue_string(logic tidy, output int n_reqs);
        logic [7:0] sb [$];
        logic [7:0] q;
        int         pieces;
        pieces = $urandom_range(0, 5);
        for (int p = 0; p < pieces; p++)
        begin
            q = $urandom_range(0, 1) ? qts_pkg::CH_DQUOTE : qts_pkg::CH_SQUOTE;
            if (!tidy)
            begin
                sb.insert(sb.size(), noise_char());
                sb.insert(sb.size(), noise_char());
            end
            else
            begin
                case ($urandom_range(0, 4))
                    0, 1:
                    begin
                        repeat ($urandom_range(1, 4))
                            sb.insert(sb.size(), $urandom_range(0, 7) == 0 ? 8'($urandom)
                                      : "a" + 8'($urandom_range(0, 25)));
                    end
                    2: sb.insert(sb.size(), active_delim());
                    3:
                    begin
                        sb.insert(sb.size(), q);
                        repeat ($urandom_range(0, 4))
                        begin
                            case ($urandom_range(0, 5))
                                0: sb.insert(sb.size(), active_delim());
                                1: sb.insert(sb.size(), q == qts_pkg::CH_DQUOTE
                                             ? qts_pkg::CH_SQUOTE : qts_pkg::CH_DQUOTE);
                                2:
                                begin
                                    // escaped open quote stays inside the section
                                    sb.insert(sb.size(), qts_pkg::CH_BSLASH);
                                    sb.insert(sb.size(), q);
                                end
                                3: sb.insert(sb.size(), qts_pkg::CH_BSLASH);
                                default: sb.insert(sb.size(), "a" + 8'($urandom_range(0, 25)));
                            endcase
                        end
                        // now and then leave the quote open
                        if ($urandom_range(0, 7) != 0)
                            sb.insert(sb.size(), q);
                    end
                    default:
                    begin
                        sb.insert(sb.size(), qts_pkg::CH_BSLASH);
                        sb.insert(sb.size(), q);
                    end
                endcase
            end
        end
        n_reqs = sb.size();
        if (sb.size() == 0 || $urandom_range(0, 4) == 0)
        begin
            // end-only request closes the string; its char field is junk
            foreach (sb[i])
                push_item(sb[i], 1'b1, 1'b0);
            push_item(8'($urandom), 1'b0, 1'b1);
            n_reqs++;
        end
        else
        begin
            foreach (sb[i])
                push_item(sb[i], 1'b1, i == sb.size() - 1);
        end
        // stray empty request between strings: block ignores it
        if ($urandom_range(0, 9) == 0)
            push_item(8'($urandom), 1'b0, 1'b0);
    endtask

    // write one register and mirror it into the model
    task automatic cfg_write(logic [2:0] idx, logic [7:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        if (idx == qts_pkg::REG_DELIM_COUNT)
            delim_count_m = val[2:0];
        else if (idx >= qts_pkg::REG_DELIM_A && idx < REG_FIRST_UNMAPPED)
            delims_m[2'(idx - qts_pkg::REG_DELIM_A)] = val;
        cfg_writes++;
    endtask

    // all four slots, the count (incl. values above the slot count, which
    // clamp) and the unmapped indexes, which must change nothing
    task automatic configure_phase(int p);
        logic [2:0] cnt;
        case (p)
            1:       cnt = 3'd4;
            2:       cnt = 3'd0;
            3:       cnt = 3'd7;
            4:       cnt = 3'd2;
            5:       cnt = 3'd5;
            default: cnt = 3'($urandom);
        endcase
        cfg_write(qts_pkg::REG_DELIM_COUNT, {5'($urandom), cnt});
        for (int i = 0; i < qts_pkg::DELIM_REGS; i++)
        begin
            if (p == 1)
                // backslash and a quote byte as delimiters, plus all-ones
                cfg_write(qts_pkg::REG_DELIM_A + 3'(i),
                          i == 0 ? qts_pkg::CH_COLON : i == 1 ? qts_pkg::CH_BSLASH
                          : i == 2 ? qts_pkg::CH_DQUOTE : 8'hFF);
            else
                cfg_write(qts_pkg::REG_DELIM_A + 3'(i), pick_delim_byte());
        end
        for (int k = 0; k < 3; k++)
            cfg_write(REG_FIRST_UNMAPPED + 3'(k), 8'($urandom));
        @(negedge clk);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    // every request taken and every result seen, then an idle margin for
    // requests that produce no result
    task automatic wait_drained();
        while (!(requests_taken == requests_queued && expected_results.size() == 0))
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        int n;
        int phase_reqs;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed part with reset settings (one delimiter, colon)
        push_text("a:b", 1'b1);                     // plain split
        push_text("::", 1'b1);                      // empty tokens, no trailing one
        push_item(8'h00, 1'b0, 1'b1);               // empty string
        push_item(8'h41, 1'b0, 1'b0);               // empty request, ignored
        push_text("\"x:\\\"\"", 1'b1);              // delimiter and escaped quote inside
        push_text("'a\\\"", 1'b1);                  // other quote after backslash; left open
        push_text("\\'\\x", 1'b1);                  // escape outside; four results at end
        push_item(8'h00, 1'b1, 1'b0);               // byte extremes
        push_item(8'hFF, 1'b1, 1'b1);
        push_text("y\\", 1'b1);                     // backslash flushed at end of string

        for (int p = 1; p <= NUM_PHASES; p++)
        begin
            wait_drained();
            configure_phase(p);
            @(posedge clk);
            phase_reqs = 0;
            while (phase_reqs < PHASE_REQS)
            begin
                queue_string($urandom_range(0, 3) != 0, n);
                phase_reqs += n;
            end
            if (p == 2)
                hold_armed = 1'b1;
        end

        wait_drained();
        repeat (4) @(negedge clk);
        if (expected_results.size() != 0)
        begin
            err_count++;
            $display("%0t: %0d expected results never arrived", $time,
                     expected_results.size());
        end

        $display("covered %0d requests and %0d results over %0d delimiter settings",
                 requests_taken, results_checked, settings_used);
        $display("%0d strings closed, %0d with an open quote, %0d register writes",
                 strings_closed, open_quote_ends, cfg_writes);
        if (err_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // run limit, far above the slowest correct run
    initial
    begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
`default_nettype wire
